@@ src/ptsd_pkg.sv @@
// Shared types, constants and the per-code decode step of the packed text decoder.
package ptsd_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int SLOTS           = 4;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ABBREV = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ALPH_LOWER = 2'd0,
    ALPH_UPPER = 2'd1,
    ALPH_PUNCT = 2'd2,
    ALPH_SPARE = 2'd3
  } alph_t;

  localparam logic ERR_ABBREV_OFF = 1'b0;
  localparam logic ERR_ESCAPE     = 1'b1;

  localparam logic [4:0] CODE_SPACE  = 5'd0;
  localparam logic [4:0] CODE_ABB_HI = 5'd3;
  localparam logic [4:0] CODE_SH_HI  = 5'd5;
  localparam logic [4:0] CODE_ESCAPE = 5'd6;

  localparam logic [6:0] ASCII_SPACE = 7'h20;
  localparam logic [6:0] LOWER_BASE  = 7'd91;  // 'a' less the first letter code
  localparam logic [6:0] UPPER_BASE  = 7'd59;  // 'A' less the first letter code

  localparam logic [6:0] PUNCT_TAB [26] = '{
    7'h20, 7'h0A, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h2E, 7'h2C, 7'h21, 7'h3F, 7'h5F, 7'h23,
    7'h27, 7'h22, 7'h2F, 7'h5C, 7'h2D, 7'h3A, 7'h28, 7'h29
  };

  // One result as it leaves the block, less the end counters
  typedef struct packed {
    kind_t      kind;
    logic [6:0] char_code;
    logic [6:0] abbrev_index;
    logic       error_code;
  } slot_t;

  // Everything one word produces
  typedef struct packed {
    logic [2:0]            cnt;
    slot_t [SLOTS-1:0]     slots;
    logic [15:0]           bytes_read;
    logic [15:0]           chars_written;
  } rec_t;

  typedef struct packed {
    alph_t      alph;
    logic [1:0] bank;
  } dec_state_t;

  typedef struct packed {
    logic       valid;
    logic       is_char;
    slot_t      slot;
    dec_state_t st;
  } dec_out_t;

  // Decode one 5-bit code against the pending shift and abbreviation bank
  function automatic dec_out_t decode_step(logic [4:0] code, dec_state_t st, logic en);
    dec_out_t   r;
    alph_t      alph;
    logic [4:0] ofs;
    r       = '0;
    r.st    = st;
    alph    = st.alph;
    ofs     = code - CODE_ESCAPE;
    if (st.bank != 2'd0) begin
      r.st.bank           = 2'd0;
      r.valid             = 1'b1;
      r.slot.kind         = en ? KIND_ABBREV : KIND_ERROR;
      r.slot.abbrev_index = {st.bank - 2'd1, code};
      r.slot.error_code   = ERR_ABBREV_OFF;
    end else begin
      r.st.alph = ALPH_LOWER;
      if (code == CODE_SPACE) begin
        r.valid          = 1'b1;
        r.is_char        = 1'b1;
        r.slot.kind      = KIND_CHAR;
        r.slot.char_code = ASCII_SPACE;
      end else if (code <= CODE_ABB_HI) begin
        r.st.bank = code[1:0];
      end else if (code <= CODE_SH_HI) begin
        if (alph == ALPH_LOWER) r.st.alph = alph_t'(code[1:0] + 2'd1);
      end else if (alph == ALPH_PUNCT && code == CODE_ESCAPE) begin
        r.valid           = 1'b1;
        r.slot.kind       = KIND_ERROR;
        r.slot.error_code = ERR_ESCAPE;
      end else begin
        r.valid     = 1'b1;
        r.is_char   = 1'b1;
        r.slot.kind = KIND_CHAR;
        case (alph)
          ALPH_UPPER: r.slot.char_code = 7'(code) + UPPER_BASE;
          ALPH_PUNCT: r.slot.char_code = PUNCT_TAB[ofs];
          default:    r.slot.char_code = 7'(code) + LOWER_BASE;
        endcase
      end
    end
    return r;
  endfunction

endpackage

@@ src/ptsd_front.sv @@
// Front end: accepts packed words, decodes the three codes and builds a result record.
`default_nettype none
module ptsd_front #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic            cfg_wr_data,
  input  wire logic            accept,
  input  wire logic [15:0]     text_word,
  output logic                 rec_push,
  output ptsd_pkg::rec_t       rec_data
);
  import ptsd_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam int EXT = 33;

  logic                  en_r;
  dec_state_t            st_r, st_nxt;
  logic [COUNT_BITS-1:0] wc_r, wc_nxt, cc_r, cc_nxt;
  logic [COUNT_BITS-1:0] wc_inc, cc_sum;
  logic [COUNT_BITS+1:0] cc_wide;
  logic [1:0]            nchars;
  logic [EXT-1:0]        wc_ext, cc_ext;
  logic [2:0]            n;
  dec_out_t              d0, d1, d2;
  rec_t                  rec;
  logic                  is_end;

  assign is_end = text_word[15];

  // Run the three codes in order, packing results into consecutive slots
  always_comb begin
    rec    = '0;
    n      = 3'd0;
    nchars = 2'd0;
    d0 = decode_step(text_word[14:10], st_r, en_r);
    d1 = decode_step(text_word[9:5],   d0.st, en_r);
    d2 = decode_step(text_word[4:0],   d1.st, en_r);
    if (d0.valid) begin
      rec.slots[n[1:0]] = d0.slot;
      n = n + 3'd1;
    end
    if (d1.valid) begin
      rec.slots[n[1:0]] = d1.slot;
      n = n + 3'd1;
    end
    if (d2.valid) begin
      rec.slots[n[1:0]] = d2.slot;
      n = n + 3'd1;
    end
    nchars = 2'(d0.is_char) + 2'(d1.is_char) + 2'(d2.is_char);

    // Saturating counters, word counted before decode
    wc_inc  = (wc_r == CNT_MAX) ? wc_r : wc_r + 1'b1;
    cc_wide = (COUNT_BITS+2)'(cc_r) + (COUNT_BITS+2)'(nchars);
    cc_sum  = (cc_wide > (COUNT_BITS+2)'(CNT_MAX)) ? CNT_MAX : cc_wide[COUNT_BITS-1:0];
    wc_ext  = EXT'(wc_inc);
    cc_ext  = EXT'(cc_sum);

    if (is_end) begin
      rec.slots[n[1:0]].kind = KIND_END;
      n = n + 3'd1;
      rec.bytes_read    = (wc_ext > EXT'(32767)) ? 16'hFFFF : 16'(wc_ext << 1);
      rec.chars_written = (cc_ext > EXT'(65535)) ? 16'hFFFF : cc_ext[15:0];
    end
    rec.cnt = n;

    // Drop pending state and counters at end of string
    st_nxt = st_r;
    wc_nxt = wc_r;
    cc_nxt = cc_r;
    if (accept) begin
      if (is_end) begin
        st_nxt = '0;
        wc_nxt = '0;
        cc_nxt = '0;
      end else begin
        st_nxt = d2.st;
        wc_nxt = wc_inc;
        cc_nxt = cc_sum;
      end
    end
  end

  assign rec_push = accept && (n != 3'd0);
  assign rec_data = rec;

  // Hold decode state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      st_r <= '0;
      wc_r <= '0;
      cc_r <= '0;
    end else begin
      if (cfg_wr_en) en_r <= cfg_wr_data;
      st_r <= st_nxt;
      wc_r <= wc_nxt;
      cc_r <= cc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/ptsd_queue.sv @@
// Short record queue between the decode front and the emit back end.
`default_nettype none
module ptsd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  ptsd_pkg::rec_t       wr_data,
  output logic                 full,
  output logic                 rd_valid,
  input  wire logic            rd_pop,
  output ptsd_pkg::rec_t       rd_data
);
  import ptsd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = rd_pop && rd_valid;

  // Store records
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/ptsd_back.sv @@
// Back end: walks each record's slots into an output register, one result per cycle while popped.
`default_nettype none
module ptsd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_valid,
  input  ptsd_pkg::rec_t       rd_data,
  output logic                 rd_pop,
  input  wire logic            pop,
  output logic                 empty,
  output logic [1:0]           out_kind,
  output logic [6:0]           out_char_code,
  output logic [6:0]           out_abbrev_index,
  output logic                 out_error_code,
  output logic [15:0]          out_bytes_read,
  output logic [15:0]          out_chars_written,
  output logic                 out_last
);
  import ptsd_pkg::*;

  logic [1:0]  idx_r;
  logic        ov_r;
  logic        load, take, at_last;
  slot_t       cur;
  logic [1:0]  kind_r;
  logic [6:0]  char_r, abb_r;
  logic        err_r, last_r;
  logic [15:0] bytes_r, chars_r;

  assign load    = !ov_r || pop;
  assign take    = load && rd_valid;
  assign cur     = rd_data.slots[idx_r];
  assign at_last = (3'(idx_r) == rd_data.cnt - 3'd1);
  assign rd_pop  = take && at_last;

  // Step through slots of the head record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else if (load) begin
      ov_r <= rd_valid;
      if (take) idx_r <= at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r  <= cur.kind;
      char_r  <= cur.char_code;
      abb_r   <= cur.abbrev_index;
      err_r   <= cur.error_code;
      last_r  <= at_last;
      bytes_r <= (cur.kind == KIND_END) ? rd_data.bytes_read : 16'd0;
      chars_r <= (cur.kind == KIND_END) ? rd_data.chars_written : 16'd0;
    end
  end

  assign empty             = !ov_r;
  assign out_kind          = kind_r;
  assign out_char_code     = char_r;
  assign out_abbrev_index  = abb_r;
  assign out_error_code    = err_r;
  assign out_bytes_read    = bytes_r;
  assign out_chars_written = chars_r;
  assign out_last          = last_r;

endmodule
`default_nettype wire

@@ src/packed_text_string_decoder_core.sv @@
// Top level of the packed text string decoder.
//
// Input channel: present a 16-bit packed word on in_text_word with push high;
// it is taken at an edge where full is low. Bit 15 marks the last word.
// Result channel: while empty is low the oldest result sits on the out_ ports;
// pop at an edge takes it. out_last flags the final result of each word.
// Config: cfg_wr_en with cfg_wr_data sets abbrev_enable (reset 1); write
// only while the block is idle.
// Path: a taken word's record is written to the queue, then its results go to the output register.
// Throughput: the back end sends one result per cycle while the receiver pops, and a
// word has 0 to 4 results (typically 3); the front takes one word per
// cycle while the record queue (QUEUE_DEPTH records) has room.
// A stalled receiver holds the output register; the queue then fills and
// full rises, while a result already waiting stays stable on the ports.
// Reset (rst_n low, synchronous) empties the queue, clears the pending shift,
// abbreviation bank and both counters, and sets abbrev_enable to 1.
`default_nettype none
module packed_text_string_decoder_core #(
  parameter int COUNT_BITS  = ptsd_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = ptsd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] in_text_word,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind,
  output logic [6:0]       out_char_code,
  output logic [6:0]       out_abbrev_index,
  output logic             out_error_code,
  output logic [15:0]      out_bytes_read,
  output logic [15:0]      out_chars_written,
  output logic             out_last
);
  import ptsd_pkg::*;

  logic rec_push, q_valid, q_pop, accept;
  rec_t rec_wr, rec_rd;

  assign accept = push && !full;

  ptsd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .accept, .text_word(in_text_word),
    .rec_push, .rec_data(rec_wr)
  );

  ptsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(rec_push), .wr_data(rec_wr), .full,
    .rd_valid(q_valid), .rd_pop(q_pop), .rd_data(rec_rd)
  );

  ptsd_back u_back (
    .clk, .rst_n, .rd_valid(q_valid), .rd_data(rec_rd), .rd_pop(q_pop),
    .pop, .empty, .out_kind, .out_char_code, .out_abbrev_index,
    .out_error_code, .out_bytes_read, .out_chars_written, .out_last
  );

endmodule
`default_nettype wire

@@ src/ptsd_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
`default_nettype none
module ptsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  out_kind,
  input wire logic [6:0]  out_char_code,
  input wire logic        out_error_code,
  input wire logic [15:0] out_bytes_read,
  input wire logic [15:0] out_chars_written,
  input wire logic        out_last
);
  import ptsd_pkg::*;

  // End of string closes its word
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_END) |-> out_last)
    else $error("end of string result without last");

  // Counters only ride on the end result
  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_END) |-> (out_bytes_read == 16'd0 &&
      out_chars_written == 16'd0))
    else $error("counters on non-end result");

  // Character code and error code follow the kind
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_kind == KIND_CHAR || out_char_code == 7'd0) &&
      (out_kind == KIND_ERROR || out_error_code == 1'b0)))
    else $error("field set for wrong kind");

  // Stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind packed_text_string_decoder_core ptsd_checker u_ptsd_checker (
  .clk, .rst_n, .empty, .pop, .out_kind, .out_char_code, .out_error_code,
  .out_bytes_read, .out_chars_written, .out_last
);
`default_nettype wire
